// File: src/base64_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// base64 decoder assertion macros
// implication checks, same cycle and next cycle, off in synthesis
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_UNIT_DEFINES_SVH
`define BASE64_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define B64D_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("b64d check failed");
`define B64D_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("b64d check failed");
`else
`define B64D_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define B64D_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// File: src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and symbol lookup for the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int MAX_SYMBOLS = 1048576;
    localparam int ST_W        = $clog2(MAX_SYMBOLS + 2);
    localparam int LEN_W       = 20;
    localparam int NEED_W      = ST_W + 3;
    localparam int CMP_W       = (NEED_W > LEN_W) ? NEED_W : LEN_W;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    typedef logic [ST_W-1:0]   sym_cnt_t;
    typedef logic [NEED_W-1:0] need_t;
    typedef logic [CMP_W-1:0]  cmp_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [Q_AW:0]     q_cnt_t;
    typedef logic [Q_AW-1:0]   q_ptr_t;

    localparam sym_cnt_t SYM_MAX  = sym_cnt_t'(MAX_SYMBOLS);
    localparam len_t     LEN_MASK = '1;
    localparam len_t     CAP_RESET = '1;

    localparam logic [7:0] SYM_PAD = 8'h40;
    localparam logic [7:0] SYM_BAD = 8'hFF;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_INVALID   = 2'd1;
    localparam logic [1:0] STAT_TOO_SMALL = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] status_code;
        len_t       length;
        logic       last_result;
    } out_item_t;

    // one queued request from front to back
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        has_status;
        logic        err;
        sym_cnt_t    sym_total;
        logic [1:0]  pad_total;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    function automatic logic [7:0] sym_value(input logic [7:0] c);
        logic [7:0] v;
        v = SYM_BAD;
        if (c >= 8'h41 && c <= 8'h5A)
            v = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)
            v = c - 8'h61 + 8'd26;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30 + 8'd52;
        else if (c == 8'h2B)
            v = 8'd62;
        else if (c == 8'h2F)
            v = 8'd63;
        else if (c == 8'h3D)
            v = SYM_PAD;
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

endpackage

// File: src/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// accepts characters, tracks group and pad state, queues group requests
// ----------------------------------------------------------------------------
module b64d_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  b64d_pkg::in_item_t   in_data,
    input  b64d_pkg::q_stat_t    q_stat,
    output logic                 q_push,
    output b64d_pkg::cmd_t       q_cmd
);

    logic [23:0]          bits_reg, bits_next;
    logic [1:0]           fill_reg, fill_next;
    logic [1:0]           bpg_reg, bpg_next;
    logic [1:0]           pad_reg, pad_next;
    b64d_pkg::sym_cnt_t   st_reg, st_next;
    logic                 err_reg, err_next;
    logic                 accept;
    logic [7:0]           sym;
    logic                 ws;
    logic                 is_pad;
    logic                 is_bad;
    logic                 grp_done;
    logic [23:0]          shifted;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign sym      = b64d_pkg::sym_value(in_data.character);
    assign ws       = b64d_pkg::is_space(in_data.character);
    assign is_pad   = (sym == b64d_pkg::SYM_PAD);
    assign is_bad   = (sym == b64d_pkg::SYM_BAD);

    always_comb
    begin
        bits_next = bits_reg;
        fill_next = fill_reg;
        bpg_next  = bpg_reg;
        pad_next  = pad_reg;
        st_next   = st_reg;
        err_next  = err_reg;
        grp_done  = 1'b0;
        shifted   = bits_reg;
        q_push    = 1'b0;
        q_cmd     = '0;
        if (accept)
        begin
            if (!err_reg && !ws)
            begin
                if (is_bad || (is_pad && pad_reg >= 2'd2) || (!is_pad && pad_reg != 2'd0))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    if (is_pad)
                    begin
                        pad_next = pad_reg + 2'd1;
                        if (bpg_reg != 2'd0)
                            bpg_next = bpg_reg - 2'd1;
                        shifted = {bits_reg[17:0], 6'd0};
                    end
                    else
                    begin
                        shifted = {bits_reg[17:0], sym[5:0]};
                    end
                    if (st_reg <= b64d_pkg::SYM_MAX)
                        st_next = st_reg + b64d_pkg::sym_cnt_t'(1);
                    if (fill_reg == 2'd3)
                    begin
                        grp_done  = 1'b1;
                        fill_next = 2'd0;
                    end
                    else
                    begin
                        fill_next = fill_reg + 2'd1;
                    end
                    bits_next = shifted;
                end
            end
            q_cmd.bits       = shifted;
            q_cmd.nbytes     = grp_done ? bpg_next : 2'd0;
            q_cmd.has_status = in_data.last_char;
            q_cmd.err        = err_next;
            q_cmd.sym_total  = st_next;
            q_cmd.pad_total  = pad_next;
            q_push           = grp_done || in_data.last_char;
            if (grp_done)
                bits_next = '0;
            if (in_data.last_char)
            begin
                bits_next = '0;
                fill_next = 2'd0;
                bpg_next  = 2'd3;
                pad_next  = 2'd0;
                st_next   = '0;
                err_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            fill_reg <= 2'd0;
            bpg_reg  <= 2'd3;
            pad_reg  <= 2'd0;
            st_reg   <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            bits_reg <= bits_next;
            fill_reg <= fill_next;
            bpg_reg  <= bpg_next;
            pad_reg  <= pad_next;
            st_reg   <= st_next;
            err_reg  <= err_next;
        end
    end

endmodule

// File: src/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// short first-in first-out queue of requests between front and back
// ----------------------------------------------------------------------------
module b64d_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64d_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output b64d_pkg::cmd_t     head,
    output b64d_pkg::q_stat_t  stat
);

    b64d_pkg::cmd_t                entry_reg [b64d_pkg::Q_DEPTH];
    b64d_pkg::q_ptr_t              wr_ptr_reg, wr_ptr_next;
    b64d_pkg::q_ptr_t              rd_ptr_reg, rd_ptr_next;
    b64d_pkg::q_cnt_t              count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == b64d_pkg::q_cnt_t'(b64d_pkg::Q_DEPTH));
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + b64d_pkg::q_ptr_t'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + b64d_pkg::q_ptr_t'(1);
        if (do_push && !do_pop)
            count_next = count_reg + b64d_pkg::q_cnt_t'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - b64d_pkg::q_cnt_t'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// expands queued requests into data bytes and the final status item
// ----------------------------------------------------------------------------
module b64d_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64d_pkg::cmd_t        head,
    input  b64d_pkg::q_stat_t     q_stat,
    output logic                  pop,
    input  b64d_pkg::len_t        capacity,
    output logic                  out_valid,
    input  logic                  out_stall,
    output b64d_pkg::out_item_t   out_data
);

    logic                   out_valid_reg, out_valid_next;
    b64d_pkg::out_item_t    out_item_reg, out_item_next;
    logic [1:0]             idx_reg, idx_next;
    b64d_pkg::len_t         bw_reg, bw_next;
    logic                   advance;
    logic                   fire;
    logic [7:0]             cur_byte;
    b64d_pkg::need_t        times6;
    b64d_pkg::sym_cnt_t     need_all;
    b64d_pkg::cmp_t         need_c;
    logic [1:0]             stat_code;
    b64d_pkg::len_t         stat_len;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = advance && q_stat.valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = head.bits[23:16];
            2'd1:    cur_byte = head.bits[15:8];
            2'd2:    cur_byte = head.bits[7:0];
            default: cur_byte = 8'd0;
        endcase
    end

    // required size: floor((6 * symbols + 7) / 8) minus pads
    assign times6   = b64d_pkg::need_t'({head.sym_total, 2'b00})
                    + b64d_pkg::need_t'({head.sym_total, 1'b0})
                    + b64d_pkg::need_t'(7);
    assign need_all = times6[b64d_pkg::NEED_W-1:3];
    assign need_c   = (need_all >= b64d_pkg::sym_cnt_t'(head.pad_total))
                    ? b64d_pkg::cmp_t'(need_all - b64d_pkg::sym_cnt_t'(head.pad_total))
                    : '0;

    always_comb
    begin
        stat_code = b64d_pkg::STAT_OK;
        stat_len  = '0;
        if (head.err)
        begin
            stat_code = b64d_pkg::STAT_INVALID;
        end
        else if (head.sym_total == '0)
        begin
            stat_code = b64d_pkg::STAT_OK;
        end
        else if (head.sym_total > b64d_pkg::SYM_MAX)
        begin
            stat_code = b64d_pkg::STAT_TOO_SMALL;
            stat_len  = b64d_pkg::LEN_MASK;
        end
        else if (need_c > b64d_pkg::cmp_t'(capacity))
        begin
            stat_code = b64d_pkg::STAT_TOO_SMALL;
            stat_len  = (need_c > b64d_pkg::cmp_t'(b64d_pkg::LEN_MASK))
                      ? b64d_pkg::LEN_MASK : need_c[b64d_pkg::LEN_W-1:0];
        end
        else
        begin
            stat_len = bw_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        idx_next       = idx_reg;
        bw_next        = bw_reg;
        pop            = 1'b0;
        if (advance)
            out_valid_next = 1'b0;
        if (fire)
        begin
            if (idx_reg < head.nbytes)
            begin
                if (bw_reg < capacity)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next             = '0;
                    out_item_next.kind        = b64d_pkg::KIND_DATA;
                    out_item_next.data_byte   = cur_byte;
                    bw_next                   = bw_reg + b64d_pkg::len_t'(1);
                end
                if ((idx_reg == head.nbytes - 2'd1) && !head.has_status)
                begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            else
            begin
                out_valid_next            = 1'b1;
                out_item_next             = '0;
                out_item_next.kind        = b64d_pkg::KIND_STATUS;
                out_item_next.status_code = stat_code;
                out_item_next.length      = stat_len;
                out_item_next.last_result = 1'b1;
                bw_next                   = '0;
                pop                       = 1'b1;
                idx_next                  = 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            bw_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            bw_reg        <= bw_next;
        end
    end

endmodule

// File: src/base64_decoder_unit.sv
// path: a group request is registered in the queue, and each result then in the output register
// throughput: one character per cycle in while the queue is not full, one result per cycle out while out_stall is low
// a group completed by the last character gives up to four results from a single
// entry of the four-entry request queue; the output byte loop sets the output rate
// reset: asynchronous, clears stream state and queue, capacity to 1048575
// ----------------------------------------------------------------------------
// base64_decoder_unit
// streaming base64 decoder top level with capacity register
// ----------------------------------------------------------------------------
`include "base64_decoder_unit_defines.svh"

module base64_decoder_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  b64d_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output b64d_pkg::out_item_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  b64d_pkg::len_t        cfg_data
);

    b64d_pkg::len_t      cap_reg, cap_next;
    logic                q_push;
    logic                q_pop;
    b64d_pkg::cmd_t      q_cmd;
    b64d_pkg::cmd_t      q_head;
    b64d_pkg::q_stat_t   q_stat;

    assign cfg_ready = 1'b1;
    assign cap_next  = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= b64d_pkg::CAP_RESET;
        else
            cap_reg <= cap_next;
    end

    b64d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    b64d_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .capacity  (cap_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `B64D_ASSERT_NOW(a_no_push_when_full, clk, rst_n, q_push, !q_stat.full)
    `B64D_ASSERT_NOW(a_pop_needs_entry, clk, rst_n, q_pop, q_stat.valid)
    `B64D_ASSERT_NOW(a_ok_within_cap, clk, rst_n, out_valid && out_data.kind == b64d_pkg::KIND_STATUS && out_data.status_code == b64d_pkg::STAT_OK, out_data.length <= cap_reg)
    `B64D_ASSERT_NEXT(a_status_ends_queue_item, clk, rst_n, q_pop && q_head.has_status && !q_push, !q_stat.full)

endmodule
